>>> src/iqm_pkg.sv
package iqm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MAG_W          = 16;
    localparam int SUM_W          = 32;
    localparam int RAD_W          = 2 * MAG_W;
    localparam int REM_W          = MAG_W + 3;
    localparam int SCALE_SHIFT    = 10;
    localparam int SAT_SHIFT      = RAD_W - SCALE_SHIFT;
    localparam int BITS_PER_STAGE = 2;
    localparam int ROOT_STAGES    = MAG_W / BITS_PER_STAGE;
    localparam int FRONT_STAGES   = 3;
    localparam int LATENCY        = FRONT_STAGES + ROOT_STAGES;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // word moving down the root pipeline
    typedef struct packed {
        logic             last;
        logic             sat;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } root_word_t;

    // one digit of the restoring square root
    function automatic root_word_t root_step(root_word_t w);
        root_word_t       o;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        o       = w;
        shifted = {w.rem[REM_W-3:0], w.rad[RAD_W-1 -: 2]};
        trial   = {1'b0, w.root, 2'b01};
        o.rad   = {w.rad[RAD_W-3:0], 2'b00};
        if (shifted >= trial)
        begin
            o.rem  = shifted - trial;
            o.root = {w.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = shifted;
            o.root = {w.root[MAG_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> src/iqm_sumsq.sv
module iqm_sumsq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [iqm_pkg::SAMPLE_W-1:0]  in_phase,
    input  logic [iqm_pkg::SAMPLE_W-1:0]  quadrature,
    input  logic                          block_end,
    output logic                          out_valid,
    output iqm_pkg::root_word_t           out_word
);
    import iqm_pkg::*;

    // stage a: absolute values
    logic                valid_a_reg, valid_a_next;
    logic                last_a_reg;
    logic [SAMPLE_W-1:0] iabs_a_reg, iabs_a_next;
    logic [SAMPLE_W-1:0] qabs_a_reg, qabs_a_next;

    // stage b: squares
    logic                valid_b_reg, valid_b_next;
    logic                last_b_reg;
    logic [SUM_W-1:0]    isq_b_reg, isq_b_next;
    logic [SUM_W-1:0]    qsq_b_reg, qsq_b_next;

    // stage c: sum, saturation flag, scaled radicand
    logic                valid_c_reg, valid_c_next;
    root_word_t          word_c_reg, word_c_next;
    logic [SUM_W-1:0]    sum;

    always_comb
    begin
        valid_a_next = in_valid;
        // most negative input maps to 2^15, which still fits unsigned
        iabs_a_next  = in_phase[SAMPLE_W-1] ? (~in_phase + 1'b1) : in_phase;
        qabs_a_next  = quadrature[SAMPLE_W-1] ? (~quadrature + 1'b1) : quadrature;

        valid_b_next = valid_a_reg;
        isq_b_next   = SUM_W'(iabs_a_reg) * SUM_W'(iabs_a_reg);
        qsq_b_next   = SUM_W'(qabs_a_reg) * SUM_W'(qabs_a_reg);

        valid_c_next     = valid_b_reg;
        sum              = isq_b_reg + qsq_b_reg;
        word_c_next.last = last_b_reg;
        word_c_next.sat  = |sum[SUM_W-1:SAT_SHIFT];
        word_c_next.rad  = {sum[SAT_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
        word_c_next.rem  = '0;
        word_c_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
            valid_c_reg <= valid_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_a_reg <= block_end;
        iabs_a_reg <= iabs_a_next;
        qabs_a_reg <= qabs_a_next;
        last_b_reg <= last_a_reg;
        isq_b_reg  <= isq_b_next;
        qsq_b_reg  <= qsq_b_next;
        word_c_reg <= word_c_next;
    end

    assign out_valid = valid_c_reg;
    assign out_word  = word_c_reg;

endmodule

>>> src/iqm_root_stage.sv
module iqm_root_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  iqm_pkg::root_word_t in_word,
    output logic                out_valid,
    output iqm_pkg::root_word_t out_word
);
    import iqm_pkg::*;

    logic       valid_reg, valid_next;
    root_word_t word_reg, word_next;

    // BITS_PER_STAGE (two) root digits per stage
    always_comb
    begin
        valid_next = in_valid;
        word_next  = in_word;
        for (int k = 0; k < BITS_PER_STAGE; k++)
        begin
            word_next = root_step(word_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> src/iq_sample_magnitude_core.sv
// iq sample magnitude: for each complex sample gives floor(32 * sqrt(I^2 + Q^2)),
// saturated at 65535, with the block_end flag carried alongside. A sample is taken
// on any clock edge with start high; busy is tied low, so a new sample can enter
// every cycle. The result appears on magnitude/block_end_out with done high for
// exactly one cycle, after three front stages (absolute value, squaring, sum
// with saturation check) and eight square-root stages of two root digits each.
// The receiver cannot stall, so every result must be captured in the cycle done
// is high. Results come out in input order.
module iq_sample_magnitude_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iqm_pkg::SAMPLE_W-1:0]  in_phase,
    input  logic [iqm_pkg::SAMPLE_W-1:0]  quadrature,
    input  logic                          block_end,
    output logic                          done,
    output logic [iqm_pkg::MAG_W-1:0]     magnitude,
    output logic                          block_end_out
);
    import iqm_pkg::*;

    // fully pipelined, never refuses a word
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // chain of valid bits and words through the root stages
    logic       chain_valid [ROOT_STAGES+1];
    root_word_t chain_word  [ROOT_STAGES+1];

    // front end: |I|, |Q|, squares, sum; radicand is 1024 * sum when not saturated
    iqm_sumsq u_sumsq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_phase   (in_phase),
        .quadrature (quadrature),
        .block_end  (block_end),
        .out_valid  (chain_valid[0]),
        .out_word   (chain_word[0])
    );

    // restoring square root, one register per stage
    for (genvar s = 0; s < ROOT_STAGES; s++)
    begin : g_root
        iqm_root_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[s]),
            .in_word   (chain_word[s]),
            .out_valid (chain_valid[s+1]),
            .out_word  (chain_word[s+1])
        );
    end

    // sum of 2^22 or more means 32 * sqrt exceeds the 16-bit range
    assign done          = chain_valid[ROOT_STAGES];
    assign magnitude     = chain_word[ROOT_STAGES].sat ? MAG_MAX : chain_word[ROOT_STAGES].root;
    assign block_end_out = chain_word[ROOT_STAGES].last;

    // every result traces back to an earlier accepted sample
    a_done_from_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY)
    ) else $error("result without matching accepted sample");

    // flag travels in lockstep with its sample
    a_last_aligned: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (block_end_out == $past(block_end, LATENCY))
    ) else $error("block_end_out misaligned");

    // final remainder of an exact floor root never exceeds twice the root
    a_root_remainder: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !chain_word[ROOT_STAGES].sat) |->
            (chain_word[ROOT_STAGES].rem <= {2'b00, chain_word[ROOT_STAGES].root, 1'b0})
    ) else $error("square root remainder out of range");

    // a zero sample must give zero magnitude
    a_zero_sample: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && ($past(in_phase, LATENCY) == '0) && ($past(quadrature, LATENCY) == '0))
            |-> (magnitude == '0)
    ) else $error("zero sample gave nonzero magnitude");

endmodule
